// File: rtl/sem_pkg.sv
package sem_pkg;

    localparam int unsigned MaxLinePixels = 1024;
    localparam int unsigned ColW          = $clog2(MaxLinePixels);
    localparam int unsigned WidthRegW     = 11;
    localparam int unsigned HeightRegW    = 13;
    localparam int unsigned MagSumW       = 17;

    localparam logic [WidthRegW-1:0]  WidthReset  = 11'd1024;
    localparam logic [HeightRegW-1:0] HeightReset = 13'd768;

    localparam logic [0:0] CfgWidth  = 1'b0;
    localparam logic [0:0] CfgHeight = 1'b1;

    typedef logic [23:0] t_pix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_OUT
    } t_state;

    // one channel's job: a 3x3 window of one channel's bytes
    typedef struct packed {
        logic [7:0] t00, t01, t02;
        logic [7:0] t10, t11, t12;
        logic [7:0] t20, t21, t22;
    } t_win;

    typedef struct packed {
        logic no_left;
        logic no_top;
        logic eol;
        logic eof;
        logic last;
    } t_tag;

endpackage

// File: rtl/sem_cell.sv
// One step of a bit-pair square root; a row of these forms the root chain.
// Each cell takes the partial remainder/root from its left neighbor and passes on.
module sem_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sem_pkg::MagSumW-1:0] i_sum,
    input  logic [8:0]                  i_root,
    input  logic [9:0]                  i_rem,
    input  logic [1:0]                  i_pair,
    output logic                        o_valid,
    output logic [sem_pkg::MagSumW-1:0] o_sum,
    output logic [8:0]                  o_root,
    output logic [9:0]                  o_rem
);
    logic [11:0] trial;
    logic [11:0] cur;
    logic        r_valid;
    logic [sem_pkg::MagSumW-1:0] r_sum;
    logic [8:0]  r_root;
    logic [9:0]  r_rem;
    logic [8:0]  n_root;
    logic [9:0]  n_rem;

    always_comb begin
        cur   = {i_rem, i_pair};
        trial = {1'b0, i_root, 2'b01};
        if (cur >= trial) begin
            n_rem  = 10'(cur - trial);
            n_root = {i_root[7:0], 1'b1};
        end else begin
            n_rem  = cur[9:0];
            n_root = {i_root[7:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sum  <= i_sum;
        r_root <= n_root;
        r_rem  <= n_rem;
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
endmodule

// File: rtl/sem_chan.sv
// Sobel sums and rounded magnitude of one channel: gradient stage, square stage,
// then a chain of eight root cells; final round and saturate.
module sem_chan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sem_pkg::t_win  i_win,
    input  logic           i_no_left,
    input  logic           i_no_top,
    output logic           o_valid,
    output logic [7:0]     o_mag
);
    logic [7:0] t00, t01, t02, t10, t20, t21;
    logic [11:0] px, nx, py, ny;
    logic [10:0] n_ax, n_ay;
    logic [10:0] r_ax, r_ay;
    logic        r_v1, r_v2;
    logic [sem_pkg::MagSumW-1:0] r_sum;
    logic [21:0] sq;
    logic        r_sat;

    logic [8:0] c_valid;
    logic [sem_pkg::MagSumW-1:0] c_sum [9];
    logic [8:0]  c_root [9];
    logic [9:0]  c_rem  [9];

    always_comb begin
        t00 = (i_no_left || i_no_top) ? 8'd0 : i_win.t00;
        t01 = i_no_top ? 8'd0 : i_win.t01;
        t02 = i_no_top ? 8'd0 : i_win.t02;
        t10 = i_no_left ? 8'd0 : i_win.t10;
        t20 = i_no_left ? 8'd0 : i_win.t20;
        t21 = i_win.t21;
        px = 12'(t02) + 12'(i_win.t12) * 12'd2 + 12'(i_win.t22);
        nx = 12'(t00) + 12'(t10) * 12'd2 + 12'(t20);
        py = 12'(t20) + 12'(t21) * 12'd2 + 12'(i_win.t22);
        ny = 12'(t00) + 12'(t01) * 12'd2 + 12'(t02);
        n_ax = (px >= nx) ? 11'(px - nx) : 11'(nx - px);
        n_ay = (py >= ny) ? 11'(py - ny) : 11'(ny - py);
    end

    assign sq = 22'(r_ax) * 22'(r_ax) + 22'(r_ay) * 22'(r_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_ax  <= n_ax;
        r_ay  <= n_ay;
        r_sat <= (sq > 22'd65280);
        r_sum <= (sq > 22'd65280) ? '0 : sq[sem_pkg::MagSumW-1:0];
    end

    assign c_valid[0] = r_v2;
    assign c_sum[0]   = r_sum;
    assign c_root[0]  = '0;
    assign c_rem[0]   = '0;

    for (genvar g = 0; g < 8; g++) begin : g_cell
        sem_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_sum   (c_sum[g]),
            .i_root  (c_root[g]),
            .i_rem   (c_rem[g]),
            .i_pair  (c_sum[g][15-2*g -: 2]),
            .o_valid (c_valid[g+1]),
            .o_sum   (c_sum[g+1]),
            .o_root  (c_root[g+1]),
            .o_rem   (c_rem[g+1])
        );
    end

    // saturation flag rides alongside the cell chain
    logic [7:0] r_satq;
    always_ff @(posedge i_clk) begin
        r_satq <= {r_satq[6:0], r_sat};
    end

    // floor root lo; round up when remainder > lo (s > lo^2 + lo)
    logic [7:0] lo;
    logic [9:0] rm;
    assign lo = c_root[8][7:0];
    assign rm = c_rem[8];

    assign o_valid = c_valid[8];
    assign o_mag   = r_satq[7] ? 8'd255 :
                     ((10'(lo) < rm) ? ((lo == 8'd255) ? 8'd255 : lo + 8'd1) : lo);
endmodule

// File: rtl/sobel_edge_magnitude_rgb.sv
// Streaming 3x3 Sobel edge magnitude on 24-bit RGB pixels.
// Input channel i_valid/o_ready carries i_operation and the pixel; operation 1
// is dropped until the frame ends; after it, every item is a drain item and
// image_width of them flush the last line. Config channel i_cfg_valid/o_cfg_ready
// writes image_width (index 0) or image_height (index 1); any write restarts the
// frame at row 0, column 0. Output channel o_valid/i_ready carries the three
// magnitudes and line, frame and run markers. An item yields zero, one or two
// results, in order. Each item is processed on its own: the line buffers are read
// at the transfer and the window shifts from the registered read, then each result
// goes through a two-stage gradient/square stage and an eight-cell root chain (one
// bit pair per cell) into the output register. A second result starts once the
// first is taken. A stalled receiver holds the output register and the block takes
// no new item until it is accepted.
// Reset clears window, position and control; line buffers are not cleared.
// Entries read before written are masked by the row position.
module sobel_edge_magnitude_rgb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_pixel_blue,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_red,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_edge_blue,
    output logic [7:0]  o_edge_green,
    output logic [7:0]  o_edge_red,
    output logic        o_end_of_line,
    output logic        o_end_of_frame,
    output logic        o_last_of_run
);
    localparam int unsigned CW = sem_pkg::ColW;

    sem_pkg::t_pix r_upper [sem_pkg::MaxLinePixels];
    sem_pkg::t_pix r_lower [sem_pkg::MaxLinePixels];
    sem_pkg::t_pix r_rd_up, r_rd_lo;

    sem_pkg::t_pix r_win [3][3];
    logic [sem_pkg::WidthRegW-1:0]  r_width;
    logic [sem_pkg::HeightRegW-1:0] r_height;
    logic [CW-1:0]                  r_col;
    logic [sem_pkg::HeightRegW-1:0] r_row;

    sem_pkg::t_state r_state, n_state;
    logic       r_two, r_second;   // second result pending
    sem_pkg::t_tag r_tag1, r_tag2;
    logic       r_drain;
    logic       r_pix_ok;          // latched item payload
    sem_pkg::t_pix r_pix;
    logic [CW-1:0] r_c;

    // effective sizes
    logic [CW:0] w_eff;
    logic [sem_pkg::HeightRegW-1:0] h_eff;
    always_comb begin
        if (r_width == '0) begin
            w_eff = (CW+1)'(1);
        end else if (r_width > sem_pkg::WidthRegW'(sem_pkg::MaxLinePixels)) begin
            w_eff = (CW+1)'(sem_pkg::MaxLinePixels);
        end else begin
            w_eff = r_width[CW:0];
        end
        h_eff = (r_height == '0) ? sem_pkg::HeightRegW'(1) : r_height;
    end

    logic acc_in, drain_now, take;
    logic [CW-1:0] c_now;
    assign drain_now = (r_row >= h_eff);
    // a config write takes the cycle; no item transfer beside it
    assign o_ready   = (r_state == sem_pkg::ST_IDLE) && !i_cfg_valid;
    assign acc_in    = i_valid && o_ready;
    assign take      = acc_in && (drain_now || !i_operation);
    assign c_now     = ((CW+1)'(r_col) >= w_eff) ? '0 : r_col;
    assign o_cfg_ready = (r_state == sem_pkg::ST_IDLE);

    logic       job_go, job_done;
    logic       chan_v [3];
    logic [7:0] mag [3];
    logic       r_launch;
    logic       r_cfire;
    sem_pkg::t_win cw [3];
    logic       c_nl, c_nt;

    // window for the current job (first or line-end result)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!r_second) begin
                cw[k] = {r_win[0][0][8*k+:8], r_win[0][1][8*k+:8], r_win[0][2][8*k+:8],
                         r_win[1][0][8*k+:8], r_win[1][1][8*k+:8], r_win[1][2][8*k+:8],
                         r_win[2][0][8*k+:8], r_win[2][1][8*k+:8], r_win[2][2][8*k+:8]};
            end else begin
                cw[k] = {r_win[0][1][8*k+:8], r_win[0][2][8*k+:8], 8'd0,
                         r_win[1][1][8*k+:8], r_win[1][2][8*k+:8], 8'd0,
                         r_win[2][1][8*k+:8], r_win[2][2][8*k+:8], 8'd0};
            end
        end
        c_nl = r_second ? r_tag2.no_left : r_tag1.no_left;
        c_nt = r_second ? r_tag2.no_top  : r_tag1.no_top;
    end

    for (genvar k = 0; k < 3; k++) begin : g_chan
        sem_chan u_chan (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (r_cfire),
            .i_win     (cw[k]),
            .i_no_left (c_nl),
            .i_no_top  (c_nt),
            .o_valid   (chan_v[k]),
            .o_mag     (mag[k])
        );
    end

    assign job_done = chan_v[0];

    // output register
    logic r_ov;
    logic [7:0] r_ob, r_og, r_or;
    sem_pkg::t_tag r_otag;
    logic r_busy;   // a job is in the chain
    logic out_free;
    assign out_free = !r_ov || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sem_pkg::ST_IDLE: if (take) n_state = sem_pkg::ST_EMIT;
            sem_pkg::ST_EMIT: begin
                if (!r_launch && !r_busy && !r_cfire && !r_ov && !r_two) begin
                    n_state = sem_pkg::ST_IDLE;
                end else if (!r_launch && !r_busy && !r_cfire && !r_two) begin
                    n_state = sem_pkg::ST_OUT;
                end
            end
            sem_pkg::ST_OUT: if (out_free) n_state = sem_pkg::ST_IDLE;
            default: n_state = sem_pkg::ST_IDLE;
        endcase
    end

    // the window shifts at the end of the first EMIT cycle; the chain samples
    // it on r_cfire, the cycle after job_go
    assign job_go = (r_state == sem_pkg::ST_EMIT) && r_launch && !r_busy && !r_cfire
                    && !r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sem_pkg::ST_IDLE;
            r_width  <= sem_pkg::WidthReset;
            r_height <= sem_pkg::HeightReset;
            r_col    <= '0;
            r_row    <= '0;
            r_launch <= 1'b0;
            r_two    <= 1'b0;
            r_second <= 1'b0;
            r_busy   <= 1'b0;
            r_cfire  <= 1'b0;
            r_ov     <= 1'b0;
            r_pix_ok <= 1'b0;
            for (int m = 0; m < 3; m++) begin
                for (int n = 0; n < 3; n++) begin
                    r_win[m][n] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            r_cfire <= job_go;
            if (job_go) r_busy <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == sem_pkg::CfgWidth) begin
                    r_width <= i_cfg_data[sem_pkg::WidthRegW-1:0];
                end else begin
                    r_height <= i_cfg_data;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (take) begin
                r_pix_ok <= 1'b1;
                r_drain  <= drain_now;
                r_pix    <= drain_now ? '0 : {i_pixel_red, i_pixel_green, i_pixel_blue};
                r_c      <= c_now;
                r_tag1 <= '{no_left: (c_now < CW'(2)), no_top: (r_row < 2), eol: 1'b0,
                            eof: 1'b0, last: !((r_row >= 1) &&
                            ((CW+1)'(c_now) == w_eff - 1'b1))};
                r_tag2 <= '{no_left: (w_eff < 2), no_top: (r_row < 2), eol: 1'b1,
                            eof: drain_now, last: 1'b1};
                r_launch <= (r_row >= 1) && (c_now >= CW'(1));
                r_two    <= (r_row >= 1) && ((CW+1)'(c_now) == w_eff - 1'b1);
                r_second <= !((r_row >= 1) && (c_now >= CW'(1)));
                if ((CW+1)'(c_now) + 1'b1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= drain_now ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= c_now + 1'b1;
                end
            end
            // window shift in the cycle after take (line buffer read registered)
            if (r_pix_ok) begin
                r_pix_ok <= 1'b0;
                for (int m = 0; m < 3; m++) begin
                    r_win[m][0] <= r_win[m][1];
                    r_win[m][1] <= r_win[m][2];
                end
                r_win[0][2] <= r_rd_up;
                r_win[1][2] <= r_rd_lo;
                r_win[2][2] <= r_pix;
                if (!r_launch && r_two) begin
                    r_launch <= 1'b1;
                    r_two    <= 1'b0;
                end
            end
            if (job_done) begin
                r_busy <= 1'b0;
                r_ov   <= 1'b1;
                if (!r_second && r_two) begin
                    r_second <= 1'b1;
                    r_two    <= 1'b0;
                end else begin
                    r_launch <= 1'b0;
                end
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output data, loaded when the chain finishes
    always_ff @(posedge i_clk) begin
        if (job_done) begin
            r_ob   <= mag[0];
            r_og   <= mag[1];
            r_or   <= mag[2];
            r_otag <= r_second ? r_tag2 : r_tag1;
        end
    end

    // upper line takes the registered lower-line word in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_up <= r_upper[c_now];
            r_rd_lo <= r_lower[c_now];
            if (!drain_now) begin
                r_lower[c_now] <= {i_pixel_red, i_pixel_green, i_pixel_blue};
            end
        end
        if (r_pix_ok && !r_drain) begin
            r_upper[r_c] <= r_rd_lo;
        end
    end

    assign o_valid        = r_ov;
    assign o_edge_blue    = r_ob;
    assign o_edge_green   = r_og;
    assign o_edge_red     = r_or;
    assign o_end_of_line  = r_otag.eol;
    assign o_end_of_frame = r_otag.eof;
    assign o_last_of_run  = r_otag.last;
endmodule
